// ===== rtl/core/scll_pkg.sv =====
// Package for the shell command line lexer.
// Holds the character codes, the lexer flag state type and the result entry type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scll_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_AMP       = 8'h26;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // Results one input item can cause: held '&', the byte itself, end marker.
    localparam int unsigned MAX_RESULTS = 3;

    typedef struct packed {
        logic in_double_quotes;
        logic in_single_quotes;
        logic escape_pending;
        logic ampersand_held;
        logic token_open;
        logic command_open;
    } lex_state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       token_begin;
        logic       command_begin;
        logic       end_marker;
        logic       run_last;
    } lex_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/shell_command_line_lexer.sv =====
// Top level of the shell command line lexer: quote-aware tokenizer over a byte stream.
// Depends on scll_pkg for character codes and the state and result types.
// The first result of an item is registered and shown in the cycle after the item is accepted.
// Flow: one item per cycle while each item causes at most one result and m_tready is high;
// an item causing more results (up to 3) holds the input while the queue drains one entry per cycle.
// Reset: aresetn is synchronous and active low; it clears the flags and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module shell_command_line_lexer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Input channel.
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] text_byte
    input  wire logic       s_tlast,   // final_byte
    // Result channel.
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [2:0]      m_tuser,   // [0] token_begin, [1] command_begin, [2] end_marker
    output logic            m_tlast    // run_last
);

    // Lexer flags, updated once for every accepted item.
    scll_pkg::lex_state_t  state_reg;
    scll_pkg::lex_state_t  state_next;

    // Result queue. Entry 0 is always the one shown on the output channel; a
    // completed transfer shifts the remaining entries down by one.
    scll_pkg::lex_result_t queue_reg [scll_pkg::MAX_RESULTS];
    scll_pkg::lex_result_t res_next  [scll_pkg::MAX_RESULTS];
    logic [1:0]            count_reg;
    logic [1:0]            count_next;

    logic [7:0] in_byte;
    logic       in_final;
    logic       in_accept;
    logic       out_pop;

    assign in_byte  = s_tdata;
    assign in_final = s_tlast;

    assign out_pop   = m_tvalid && m_tready;
    // A new item is taken when the queue is empty, or when its only entry
    // leaves in this same cycle; the new results then fill it from the bottom.
    assign s_tready  = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_tready);
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = queue_reg[0].out_byte;
    assign m_tuser  = {queue_reg[0].end_marker, queue_reg[0].command_begin,
                       queue_reg[0].token_begin};
    assign m_tlast  = queue_reg[0].run_last;

    function automatic scll_pkg::lex_result_t make_result(
        input logic [7:0] value,
        input logic       tb,
        input logic       cb,
        input logic       em
    );
        scll_pkg::lex_result_t r;
        r.out_byte      = value;
        r.token_begin   = tb;
        r.command_begin = cb;
        r.end_marker    = em;
        r.run_last      = 1'b0;
        return r;
    endfunction

    // Single pass over one byte. The flags are worked through in the same order
    // as the lexing rules: release or merge a held ampersand first, then the
    // escape and quote handling, then the byte's own effect, then the flush on
    // the final byte.
    always_comb begin
        scll_pkg::lex_state_t st;
        logic [1:0] n;
        logic       consumed;
        logic       dropped;
        logic       quoted;
        logic       blank;

        st       = state_reg;
        n        = 2'd0;
        consumed = 1'b0;
        dropped  = 1'b0;
        quoted   = 1'b0;
        blank    = 1'b0;
        for (int i = 0; i < scll_pkg::MAX_RESULTS; i++) begin
            res_next[i] = '0;
        end

        if (st.ampersand_held) begin
            st.ampersand_held = 1'b0;
            if (in_byte == scll_pkg::CH_AMP) begin
                // Unquoted "&&": ends the command, both characters vanish.
                st.token_open   = 1'b0;
                st.command_open = 1'b0;
                consumed        = 1'b1;
            end else begin
                res_next[n]     = make_result(scll_pkg::CH_AMP, !st.token_open,
                                              !st.command_open, 1'b0);
                st.token_open   = 1'b1;
                st.command_open = 1'b1;
                n               = n + 2'd1;
            end
        end

        if (!consumed) begin
            // A backslash only shields the next byte from toggling a quote
            // state; the backslash is kept as a token byte and the next byte has its usual effect.
            if (st.escape_pending) begin
                st.escape_pending = 1'b0;
            end else if (in_byte == scll_pkg::CH_BACKSLASH) begin
                st.escape_pending = 1'b1;
            end else if (in_byte == scll_pkg::CH_DQUOTE && !st.in_single_quotes) begin
                st.in_double_quotes = !st.in_double_quotes;
                dropped             = 1'b1;
            end else if (in_byte == scll_pkg::CH_SQUOTE && !st.in_double_quotes) begin
                st.in_single_quotes = !st.in_single_quotes;
                dropped             = 1'b1;
            end

            if (!dropped) begin
                quoted = st.in_double_quotes || st.in_single_quotes;
                blank  = (in_byte inside {[scll_pkg::CH_TAB:scll_pkg::CH_CR],
                                          scll_pkg::CH_SPACE});
                if (!quoted && in_byte == scll_pkg::CH_AMP) begin
                    st.ampersand_held = 1'b1;
                end else if (!quoted && in_byte == scll_pkg::CH_NEWLINE) begin
                    st.token_open   = 1'b0;
                    st.command_open = 1'b0;
                end else if (!quoted && blank) begin
                    st.token_open = 1'b0;
                end else begin
                    res_next[n]     = make_result(in_byte, !st.token_open,
                                                  !st.command_open, 1'b0);
                    st.token_open   = 1'b1;
                    st.command_open = 1'b1;
                    n               = n + 2'd1;
                end
            end
        end

        if (in_final) begin
            // Flush a held ampersand, add the end marker and return to reset.
            if (st.ampersand_held) begin
                res_next[n] = make_result(scll_pkg::CH_AMP, !st.token_open,
                                          !st.command_open, 1'b0);
                n           = n + 2'd1;
            end
            res_next[n] = make_result(8'h00, 1'b0, 1'b0, 1'b1);
            n           = n + 2'd1;
            st          = '0;
        end

        for (int i = 0; i < scll_pkg::MAX_RESULTS; i++) begin
            res_next[i].run_last = (2'(i + 1) == n);
        end

        state_next = st;
        count_next = n;
    end

    // Flags and queue occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            count_reg <= 2'd0;
        end else begin
            if (in_accept) begin
                state_reg <= state_next;
                count_reg <= count_next;
            end else if (out_pop) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Queue payload: loaded whole on an accepted item, shifted on a transfer.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            for (int i = 0; i < scll_pkg::MAX_RESULTS; i++) begin
                queue_reg[i] <= res_next[i];
            end
        end else if (out_pop) begin
            for (int i = 0; i < scll_pkg::MAX_RESULTS - 1; i++) begin
                queue_reg[i] <= queue_reg[i + 1];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/scll_checker.sv =====
// Port-level checker for the shell command line lexer, bound to the top level.
// Depends only on the ports of shell_command_line_lexer.
`timescale 1ns / 1ps
`default_nettype none

module scll_props (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [2:0] m_tuser,
    input wire logic       m_tlast
);

    // A result waiting to be taken stays on offer.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before it was taken");

    // The end marker is always the last result of its item and carries nothing.
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tlast && m_tdata == 8'h00 && m_tuser[1:0] == 2'b00)
        else $error("end marker malformed or not last");

    // A byte that opens a command always opens a token as well.
    a_cmd_opens_token: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("command begin without token begin");

    // With nothing waiting on the output, the input is always open.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input closed while no result is waiting");

    // Reset leaves nothing on offer.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown straight after reset");

endmodule

bind shell_command_line_lexer scll_props u_scll_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
